// File: sv/sle_pkg.sv
// Sorted list engine package: action and status codes, cell control type,
// default sizes. Used by sle_cell and sorted_list_engine_top.
package sle_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned VALUE_BITS = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_READ   = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic insert;
    logic erase;
  } cell_ctrl_t;

endpackage

// File: sv/sle_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the item
// value, and takes the new value or a neighbor's entry. Uses sle_pkg.
module sle_cell #(
  parameter int unsigned VALUE_BITS = sle_pkg::VALUE_BITS
) (
  input  logic                    clk_i,
  input  sle_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    slot_valid_i,
  input  logic                    prev_lt_i,
  input  logic                    after_idx_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  input  logic [VALUE_BITS-1:0]   left_i,
  input  logic [VALUE_BITS-1:0]   right_i,
  output logic [VALUE_BITS-1:0]   entry_o,
  output logic                    lt_o,
  output logic                    eq_o
);

  logic [VALUE_BITS-1:0] entry_q, entry_d;

  assign lt_o    = slot_valid_i && (entry_q < value_i);
  assign eq_o    = slot_valid_i && (entry_q == value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && !lt_o) begin
      entry_d = prev_lt_i ? value_i : left_i;
    end else if (ctrl_i.erase && after_idx_i) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: sv/sorted_list_engine_top.sv
// Sorted list engine top level: chain of sle_cell slots, entry count,
// position encoders and the result register. Uses sle_pkg and sle_cell.
//
// Usage: one item on the input channel (action_i, item_value_i, item_index_i)
// yields exactly one result item (status_o, position_o, read_value_o,
// entry_total_o) on the output channel. Both channels use valid/stall; an
// item moves at an edge where valid is high and stall is low.
// All cells compare against the item value in parallel, and the chain shifts
// by one slot on insert or erase. The result is registered in the output
// register at the acceptance edge; throughput is one item per cycle while
// the output side takes results. While a result waits under out_stall_i,
// in_stall_o is raised and the held result stays unchanged.
// Reset empties the list (count zero) and drops any waiting result; slot
// contents are left as they are and are never read before written.
// Insert places a value before equal entries; find gives the lowest match.
module sorted_list_engine_top #(
  parameter int unsigned CAPACITY   = sle_pkg::CAPACITY,
  parameter int unsigned VALUE_BITS = sle_pkg::VALUE_BITS,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            action_i,
  input  logic [VALUE_BITS-1:0] item_value_i,
  input  logic [IdxW-1:0]       item_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [CntW-1:0]       position_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [CntW-1:0]       entry_total_o
);

  logic                  accept;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       idx_ext;
  logic                  full, idx_ok;
  logic [CAPACITY-1:0]   lt, eq;
  logic [VALUE_BITS-1:0] entries [CAPACITY];
  logic [CntW-1:0]       ins_pos, find_pos;
  logic                  found;
  sle_pkg::cell_ctrl_t   ctrl;

  logic                  out_valid_q;
  sle_pkg::status_e      status_q, status_d;
  logic [CntW-1:0]       position_q, position_d;
  logic [VALUE_BITS-1:0] read_value_q, read_value_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_ext    = CntW'(item_index_i);
  assign full       = (count_q >= CntW'(CAPACITY));
  assign idx_ok     = (idx_ext < count_q);

  assign ctrl.insert = accept && (action_i == sle_pkg::ACT_INSERT) && !full;
  assign ctrl.erase  = accept && (action_i == sle_pkg::ACT_ERASE) && idx_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = item_value_i;
    end else begin : g_left
      assign left = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = entries[i];
    end else begin : g_right
      assign right = entries[i+1];
    end
    sle_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .slot_valid_i (CntW'(i) < count_q),
      .prev_lt_i    ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .after_idx_i  (CntW'(i) >= idx_ext),
      .value_i      (item_value_i),
      .left_i       (left),
      .right_i      (right),
      .entry_o      (entries[i]),
      .lt_o         (lt[i]),
      .eq_o         (eq[i])
    );
  end

  always_comb begin
    ins_pos  = count_q;
    find_pos = '0;
    found    = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt[i]) begin
        ins_pos = CntW'(i);
      end
      if (eq[i]) begin
        find_pos = CntW'(i);
        found    = 1'b1;
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    status_d     = sle_pkg::ST_OK;
    position_d   = '0;
    read_value_d = '0;
    unique case (action_i)
      sle_pkg::ACT_INSERT: begin
        if (full) begin
          status_d = sle_pkg::ST_FULL;
        end else begin
          position_d = ins_pos;
          count_d    = count_q + CntW'(1);
        end
      end
      sle_pkg::ACT_READ: begin
        if (!idx_ok) begin
          status_d = sle_pkg::ST_RANGE;
        end else begin
          read_value_d = entries[item_index_i];
        end
      end
      sle_pkg::ACT_ERASE: begin
        if (!idx_ok) begin
          status_d = sle_pkg::ST_RANGE;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      sle_pkg::ACT_FIND: begin
        if (found) begin
          position_d = find_pos;
        end else begin
          status_d = sle_pkg::ST_NOTFOUND;
        end
      end
      sle_pkg::ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      position_q   <= position_d;
      read_value_q <= read_value_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign read_value_o  = read_value_q;
  assign entry_total_o = count_q;

endmodule

// File: verif/sorted_list_engine_checker.sv
// Checker for sorted_list_engine_top: watches both channels, keeps its own
// ordered list to predict each result and compares field by field.
// Depends on sle_pkg for sizes, action and status codes.
module sorted_list_engine_checker
  import sle_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [2:0]                        action_i,
  input  logic [VALUE_BITS-1:0]             item_value_i,
  input  logic [$clog2(CAPACITY)-1:0]       item_index_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [1:0]                        status_i,
  input  logic [$clog2(CAPACITY + 1)-1:0]   position_i,
  input  logic [VALUE_BITS-1:0]             read_value_i,
  input  logic [$clog2(CAPACITY + 1)-1:0]   entry_total_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                items_o,
  output int                                results_o,
  output int                                full_hits_o,
  output int                                miss_hits_o,
  output int                                range_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef struct packed {
    status_e               status;
    logic [CntW-1:0]       position;
    logic [VALUE_BITS-1:0] read_value;
    logic [CntW-1:0]       entry_total;
  } list_result_t;

  logic [VALUE_BITS-1:0] list_entries [CAPACITY];
  int                    list_count;
  list_result_t          expected_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    items_o      = 0;
    results_o    = 0;
    full_hits_o  = 0;
    miss_hits_o  = 0;
    range_hits_o = 0;
    list_count   = 0;
  end

  function automatic list_result_t apply_list_action(logic [2:0] act,
                                                     logic [VALUE_BITS-1:0] val,
                                                     logic [IdxW-1:0] idx);
    list_result_t r;
    int           slot;
    int           k;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < list_count && list_entries[slot] < val) slot++;
          for (k = list_count; k > slot; k--) list_entries[k] = list_entries[k-1];
          list_entries[slot] = val;
          list_count++;
          r.position = CntW'(slot);
        end
      end
      ACT_READ: begin
        if (int'(idx) >= list_count) r.status = ST_RANGE;
        else r.read_value = list_entries[idx];
      end
      ACT_ERASE: begin
        if (int'(idx) >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = int'(idx); k + 1 < list_count; k++) list_entries[k] = list_entries[k+1];
          list_count--;
        end
      end
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        for (k = 0; k < list_count; k++) begin
          if (list_entries[k] == val) begin
            r.status   = ST_OK;
            r.position = CntW'(k);
            break;
          end
        end
      end
      ACT_CLEAR: begin
        list_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_total = CntW'(list_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned exp_val);
    $display("[%0t] mismatch %s: got 0x%0h, predicted 0x%0h", $realtime, what, got,
             exp_val);
    fail_count_o++;
  endtask

  task automatic check_result();
    list_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no item pending", status_i, 0);
      return;
    end
    want = expected_results.pop_front();
    results_o++;
    if (want.status == ST_FULL) full_hits_o++;
    if (want.status == ST_NOTFOUND) miss_hits_o++;
    if (want.status == ST_RANGE) range_hits_o++;
    if (status_i !== want.status) report_mismatch("status", status_i, want.status);
    if (position_i !== want.position) report_mismatch("position", position_i, want.position);
    if (read_value_i !== want.read_value)
      report_mismatch("read_value", read_value_i, want.read_value);
    if (entry_total_i !== want.entry_total)
      report_mismatch("entry_total", entry_total_i, want.entry_total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_list_action(action_i, item_value_i, item_index_i));
        items_o++;
      end
      if (out_valid_i && !out_stall_i) check_result();
    end
    pending_o = expected_results.size();
  end

endmodule

// File: verif/sorted_list_engine_top_tb.sv
// Testbench top for sorted_list_engine_top: clock, reset, directed and random
// list actions with idling and a long output hold-off, and the verdict.
// Depends on sle_pkg, the engine RTL and sorted_list_engine_checker.
module sorted_list_engine_top_tb;
  import sle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW        = $clog2(CAPACITY);
  localparam int unsigned CntW        = $clog2(CAPACITY + 1);
  localparam int          HOLD_CYCLES = 48;
  localparam int          PHASE_ITEMS = 345;
  localparam int          BLOCK_ITEMS = 40;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic [2:0]            action_i     = '0;
  logic [VALUE_BITS-1:0] item_value_i = '0;
  logic [IdxW-1:0]       item_index_i = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [1:0]            status_o;
  logic [CntW-1:0]       position_o;
  logic [VALUE_BITS-1:0] read_value_o;
  logic [CntW-1:0]       entry_total_o;

  int fail_count, pending, items, results, full_hits, miss_hits, range_hits;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks   = 0;
  int hold_done   = 0;

  logic [VALUE_BITS-1:0] value_pool [8] = '{32'h0, 32'h1, 32'h7, 32'h7,
    32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

  sorted_list_engine_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .item_value_i  (item_value_i),
    .item_index_i  (item_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .read_value_o  (read_value_o),
    .entry_total_o (entry_total_o)
  );

  sorted_list_engine_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .item_value_i  (item_value_i),
    .item_index_i  (item_index_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .position_i    (position_o),
    .read_value_i  (read_value_o),
    .entry_total_i (entry_total_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .items_o       (items),
    .results_o     (results),
    .full_hits_o   (full_hits),
    .miss_hits_o   (miss_hits),
    .range_hits_o  (range_hits)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200_000;
    $display("** sorted_list_engine_top: FAILED **");
    $finish;
  end

  // receiver: random stall, or a long hold when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done++;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic offer_item(logic [2:0] act, logic [VALUE_BITS-1:0] val,
                            logic [IdxW-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    item_value_i <= val;
    item_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic offer_random(bit fill_bias);
    int                    pick;
    logic [2:0]            act;
    logic [VALUE_BITS-1:0] val;
    logic [IdxW-1:0]       idx;
    pick = $urandom_range(99);
    if (fill_bias) begin
      if (pick < 65) act = ACT_INSERT;
      else if (pick < 80) act = ACT_READ;
      else if (pick < 93) act = ACT_FIND;
      else if (pick < 98) act = ACT_ERASE;
      else act = 3'($urandom_range(7, 5));
    end else begin
      if (pick < 12) act = ACT_INSERT;
      else if (pick < 30) act = ACT_READ;
      else if (pick < 48) act = ACT_FIND;
      else if (pick < 93) act = ACT_ERASE;
      else if (pick < 96) act = ACT_CLEAR;
      else act = 3'($urandom_range(7, 5));
    end
    val = ($urandom_range(99) < 55) ? value_pool[$urandom_range(7)] : $urandom();
    idx = ($urandom_range(99) < 40) ? IdxW'($urandom_range(3)) : IdxW'($urandom_range(15));
    offer_item(act, val, idx);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, extremes, equal values, unused codes, clear
    offer_item(ACT_READ, '0, '0);
    offer_item(ACT_FIND, 32'h5, '0);
    offer_item(ACT_ERASE, '0, '0);
    offer_item(ACT_INSERT, 32'hFFFF_FFFF, '0);
    offer_item(ACT_INSERT, 32'h0, '0);
    offer_item(ACT_INSERT, 32'h5, '0);
    offer_item(ACT_INSERT, 32'h5, 4'hF);
    offer_item(ACT_FIND, 32'h5, '0);
    offer_item(ACT_FIND, 32'hFFFF_FFFF, '0);
    offer_item(ACT_READ, '0, 4'd3);
    offer_item(ACT_READ, '0, 4'd4);
    offer_item(ACT_READ, '0, 4'hF);
    offer_item(ACT_ERASE, '0, 4'd1);
    offer_item(ACT_ERASE, '0, 4'hF);
    offer_item(3'd5, 32'hFFFF_FFFF, 4'hF);
    offer_item(3'd6, 32'hAAAA_5555, 4'hA);
    offer_item(3'd7, 32'h5555_AAAA, 4'h5);
    offer_item(ACT_CLEAR, 32'hFFFF_FFFF, 4'hF);
    offer_item(ACT_READ, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 60 : 0;
      rx_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 27 : 0;
      if (phase != 1) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) offer_random(((n / BLOCK_ITEMS) % 2) == 0);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Ran %0d items of every action and unused code, %0d results checked.",
             items, results);
    $display("Full list %0d times, missed finds %0d, out of range %0d, outstanding %0d.",
             full_hits, miss_hits, range_hits, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** sorted_list_engine_top: PASSED **");
    end else begin
      $display("** sorted_list_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
